>>> sv/utf8v_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8v_pkg
// Shared types and constants for the UTF-8 validator with UTF-16 unit count.
// ----------------------------------------------------------------------------
package utf8v_pkg;

	localparam int MAX_UNITS      = 4095;
	localparam int UNIT_FIELD_MAX = 4095;
	localparam int UNIT_W         = 12;
	localparam int CP_W           = 21;

	// effective saturation point of the unit counter
	localparam logic [UNIT_W-1:0] UNIT_CAP =
		UNIT_W'((MAX_UNITS < UNIT_FIELD_MAX) ? MAX_UNITS : UNIT_FIELD_MAX);

	localparam logic [CP_W-1:0] CP_MAX  = 21'h10FFFF;
	localparam logic [CP_W-1:0] SURR_LO = 21'h00D800;
	localparam logic [CP_W-1:0] SURR_HI = 21'h00DFFF;
	localparam logic [CP_W-1:0] BMP_MAX = 21'h00FFFF;

	// lead and continuation byte patterns
	localparam logic [7:0] ASCII_LIM = 8'h80;
	localparam logic [7:0] MASK_2B   = 8'hE0;
	localparam logic [7:0] LEAD_2B   = 8'hC0;
	localparam logic [7:0] MASK_3B   = 8'hF0;
	localparam logic [7:0] LEAD_3B   = 8'hE0;
	localparam logic [7:0] MASK_4B   = 8'hF8;
	localparam logic [7:0] LEAD_4B   = 8'hF0;
	localparam logic [7:0] MASK_CONT = 8'hC0;
	localparam logic [7:0] CONT_PAT  = 8'h80;
	localparam logic [7:0] CONT_BITS = 8'h3F;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_beat_t;

	typedef struct packed {
		logic [UNIT_W-1:0] unit_count;
		logic              bad_utf8;
	} result_t;

endpackage

>>> sv/utf8v_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8v_in_if
// Byte channel: one string byte per beat, with a flag on the final byte.
// ----------------------------------------------------------------------------
interface utf8v_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> sv/utf8v_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8v_out_if
// Result channel: one beat per string with the UTF-16 unit count and flag.
// ----------------------------------------------------------------------------
interface utf8v_out_if;
	import utf8v_pkg::*;
	logic              valid;
	logic              ready;
	logic [UNIT_W-1:0] unit_count;
	logic              bad_utf8;

	modport source (output valid, output unit_count, output bad_utf8, input ready);
	modport sink   (input valid, input unit_count, input bad_utf8, output ready);
endinterface

>>> sv/utf8v_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8v_core
// Running decode state and per-byte next-state logic; gives the string
// result on the final byte and returns to the start state.
// ----------------------------------------------------------------------------
module utf8v_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  utf8v_pkg::in_beat_t beat,
	output utf8v_pkg::result_t  result
);
	import utf8v_pkg::*;

	logic [1:0]        pending_q;
	logic [CP_W-1:0]   acc_q;
	logic [UNIT_W-1:0] units_q;
	logic              err_q;

	logic [1:0]        pending_d;
	logic [CP_W-1:0]   acc_d;
	logic [UNIT_W-1:0] units_d;
	logic              err_d;

	logic              fin;
	logic [CP_W-1:0]   fin_cp;
	logic [UNIT_W:0]   sum;
	logic              bad_end;

	always_comb begin
		logic [7:0] b;
		b         = beat.data_byte;
		pending_d = pending_q;
		acc_d     = acc_q;
		err_d     = err_q;
		fin       = 1'b0;
		fin_cp    = '0;
		if (!err_q) begin
			if (pending_q == 2'd0) begin
				if (b < ASCII_LIM) begin
					fin    = 1'b1;
					fin_cp = CP_W'(b);
				end else if ((b & MASK_2B) == LEAD_2B) begin
					pending_d = 2'd1;
					acc_d     = CP_W'(b[4:0]);
				end else if ((b & MASK_3B) == LEAD_3B) begin
					pending_d = 2'd2;
					acc_d     = CP_W'(b[3:0]);
				end else if ((b & MASK_4B) == LEAD_4B) begin
					pending_d = 2'd3;
					acc_d     = CP_W'(b[2:0]);
				end else begin
					err_d = 1'b1;
				end
			end else if ((b & MASK_CONT) != CONT_PAT) begin
				err_d     = 1'b1;
				pending_d = 2'd0;
			end else begin
				acc_d     = {acc_q[CP_W-7:0], b[5:0] & CONT_BITS[5:0]};
				pending_d = pending_q - 2'd1;
				if (pending_d == 2'd0) begin
					fin    = 1'b1;
					fin_cp = acc_d;
				end
			end
		end

		// close a finished code point: range and surrogate check, then count
		units_d = units_q;
		sum     = {1'b0, units_q} + ((fin_cp > BMP_MAX) ? (UNIT_W+1)'(2) : (UNIT_W+1)'(1));
		if (fin) begin
			if (fin_cp > CP_MAX || (fin_cp >= SURR_LO && fin_cp <= SURR_HI)) begin
				err_d = 1'b1;
			end else if (sum > {1'b0, UNIT_CAP}) begin
				units_d = UNIT_CAP;
			end else begin
				units_d = sum[UNIT_W-1:0];
			end
		end

		bad_end           = err_d || (pending_d != 2'd0);
		result.bad_utf8   = bad_end;
		result.unit_count = bad_end ? '0 : units_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			acc_q     <= '0;
			units_q   <= '0;
			err_q     <= 1'b0;
		end else if (step) begin
			if (beat.last_byte) begin
				pending_q <= '0;
				acc_q     <= '0;
				units_q   <= '0;
				err_q     <= 1'b0;
			end else begin
				pending_q <= pending_d;
				acc_q     <= acc_d;
				units_q   <= units_d;
				err_q     <= err_d;
			end
		end
	end

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		step && beat.last_byte |=> pending_q == 2'd0 && units_q == '0 && !err_q)
		else $error("decode state not cleared after final byte");

	a_count_capped: assert property (@(posedge clk) disable iff (!arst_n)
		units_q <= UNIT_CAP)
		else $error("unit count above saturation point");

	a_err_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		step && err_q && !beat.last_byte |=> err_q && $stable(units_q))
		else $error("decode continued after an error");

endmodule

>>> sv/utf8_validate_utf16_length.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_validate_utf16_length
// UTF-8 validator that reports the UTF-16 length of each string.
// ----------------------------------------------------------------------------
// Feed a string one byte per beat on text, with last_byte set on its final
// byte; one beat on result per string follows, carrying the UTF-16 unit count
// (saturating) and bad_utf8, with the count forced to zero for a bad string.
// The block takes one byte every cycle unless a final byte waits: each byte
// passes an input register and is decoded against the running state, and
// the result of a final byte is stored in a result register that drives the
// result beat. Only a final byte waits in the input register while the
// previous result is still unclaimed.
module utf8_validate_utf16_length (
	input  logic         clk,
	input  logic         arst_n,
	utf8v_in_if.sink     text,
	utf8v_out_if.source  result
);
	import utf8v_pkg::*;

	logic     valid_s1;
	in_beat_t beat_s1;
	logic     adv_s1;
	logic     out_free;
	result_t  res_d;
	result_t  res_q;
	logic     out_valid_q;

	assign out_free   = !out_valid_q || result.ready;
	// a final byte needs the result register; other bytes always move on
	assign adv_s1     = valid_s1 && (!beat_s1.last_byte || out_free);
	assign text.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			beat_s1.data_byte <= text.data_byte;
			beat_s1.last_byte <= text.last_byte;
		end
	end

	utf8v_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv_s1),
		.beat   (beat_s1),
		.result (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv_s1 && beat_s1.last_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && adv_s1 && beat_s1.last_byte) begin
			res_q <= res_d;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.unit_count = res_q.unit_count;
	assign result.bad_utf8   = res_q.bad_utf8;

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.bad_utf8 |-> result.unit_count == '0)
		else $error("bad string reported with nonzero count");

	a_stall_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |-> beat_s1.last_byte && out_valid_q && !result.ready)
		else $error("input stage stalled without a blocked result");

	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(adv_s1 && beat_s1.last_byte))
		else $error("result raised without a final byte");

endmodule

>>> tb/sv/utf16_length_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf16_length_checker
// Watches the byte and result channels, predicts each string's UTF-16 length
// and validity from the accepted bytes, and compares every result beat.
// ----------------------------------------------------------------------------
module utf16_length_checker (
	input  logic  clk,
	input  logic  arst_n,
	utf8v_in_if   text,
	utf8v_out_if  result,
	output int    fail_count,
	output int    results_left,
	output int    strings_checked,
	output int    bad_strings
);
	import utf8v_pkg::*;

	logic [1:0]        cont_left;
	logic [CP_W-1:0]   cp_acc;
	logic [UNIT_W-1:0] unit_total;
	logic              str_bad;
	result_t           expected_lengths[$];
	int                mismatches;
	int                checked;
	int                flagged;

	function automatic void count_code_point(logic [CP_W-1:0] cp);
		int unsigned grown;
		if (cp > CP_MAX || (cp >= SURR_LO && cp <= SURR_HI)) begin
			str_bad = 1'b1;
			return;
		end
		grown = unit_total + ((cp > BMP_MAX) ? 2 : 1);
		unit_total = (grown > UNIT_CAP) ? UNIT_CAP : UNIT_W'(grown);
	endfunction

	function automatic void absorb_byte(logic [7:0] b);
		if (cont_left == 2'd0) begin
			if (b < ASCII_LIM) begin
				count_code_point(CP_W'(b));
			end else if ((b & MASK_2B) == LEAD_2B) begin
				cont_left = 2'd1;
				cp_acc = CP_W'(b & ~MASK_2B);
			end else if ((b & MASK_3B) == LEAD_3B) begin
				cont_left = 2'd2;
				cp_acc = CP_W'(b & ~MASK_3B);
			end else if ((b & MASK_4B) == LEAD_4B) begin
				cont_left = 2'd3;
				cp_acc = CP_W'(b & ~MASK_4B);
			end else begin
				str_bad = 1'b1;
			end
			return;
		end
		if ((b & MASK_CONT) != CONT_PAT) begin
			str_bad = 1'b1;
			cont_left = 2'd0;
			return;
		end
		cp_acc = {cp_acc[CP_W-7:0], b[5:0]};
		cont_left = cont_left - 2'd1;
		if (cont_left == 2'd0)
			count_code_point(cp_acc);
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		result_t due;
		result_t got;
		if (!arst_n) begin
			cont_left = '0;
			cp_acc = '0;
			unit_total = '0;
			str_bad = 1'b0;
			expected_lengths.delete();
			mismatches = 0;
			checked = 0;
			flagged = 0;
		end else begin
			// check the result beat first: it can only belong to an earlier string
			if (result.valid && result.ready) begin
				got.unit_count = result.unit_count;
				got.bad_utf8 = result.bad_utf8;
				if (expected_lengths.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%t: result beat with none expected: count %0d bad %0b",
							$realtime, got.unit_count, got.bad_utf8);
				end else begin
					due = expected_lengths.pop_front();
					checked++;
					if (due.bad_utf8)
						flagged++;
					if (got.unit_count !== due.unit_count || got.bad_utf8 !== due.bad_utf8) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%t: string %0d: count %0d bad %0b, expected count %0d bad %0b",
								$realtime, checked, got.unit_count, got.bad_utf8,
								due.unit_count, due.bad_utf8);
					end
				end
			end
			if (text.valid && text.ready) begin
				if (!str_bad)
					absorb_byte(text.data_byte);
				if (text.last_byte) begin
					// a sequence cut short at the end spoils the string
					if (cont_left != 2'd0)
						str_bad = 1'b1;
					due.unit_count = str_bad ? '0 : unit_total;
					due.bad_utf8 = str_bad;
					expected_lengths.push_back(due);
					cont_left = '0;
					cp_acc = '0;
					unit_total = '0;
					str_bad = 1'b0;
				end
			end
		end
		fail_count <= mismatches;
		results_left <= expected_lengths.size();
		strings_checked <= checked;
		bad_strings <= flagged;
	end

endmodule

>>> tb/sv/utf8_validate_utf16_length_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_validate_utf16_length_tb
// Feeds directed and random UTF-8 strings through the validator under three
// pacing phases and lets the checker compare every UTF-16 length result.
// ----------------------------------------------------------------------------
module utf8_validate_utf16_length_tb;
	import utf8v_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int RANDOM_BYTES = 1050;

	logic clk = 1'b0;
	logic arst_n;

	utf8v_in_if  text();
	utf8v_out_if result();

	int         fail_count;
	int         results_left;
	int         strings_checked;
	int         bad_strings;
	int         tx_idle_pct;
	int         rx_idle_pct;
	int         bytes_sent;
	int         stall_cycles;
	logic [7:0] str_buf[$];

	utf8_validate_utf16_length u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.result (result)
	);

	utf16_length_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.text            (text),
		.result          (result),
		.fail_count      (fail_count),
		.results_left    (results_left),
		.strings_checked (strings_checked),
		.bad_strings     (bad_strings)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		result.ready <= arst_n && ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (text.valid && text.ready) || (result.valid && result.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("%t: no beat moved for %0d cycles", $realtime, STALL_LIMIT);
			$display("Some tests failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic send_byte(logic [7:0] b, logic fin);
		while ($urandom_range(99) < tx_idle_pct) begin
			text.valid <= 1'b0;
			@(posedge clk);
		end
		text.valid <= 1'b1;
		text.data_byte <= b;
		text.last_byte <= fin;
		@(posedge clk);
		while (!text.ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_string();
		int i;
		for (i = 0; i < str_buf.size(); i++)
			send_byte(str_buf[i], i == str_buf.size() - 1);
	endtask

	function automatic void push_char(int nb, logic [CP_W-1:0] cp);
		case (nb)
			1: str_buf.push_back(8'(cp[6:0]));
			2: begin
				str_buf.push_back(LEAD_2B | 8'(cp[10:6]));
				str_buf.push_back(CONT_PAT | 8'(cp[5:0]));
			end
			3: begin
				str_buf.push_back(LEAD_3B | 8'(cp[15:12]));
				str_buf.push_back(CONT_PAT | 8'(cp[11:6]));
				str_buf.push_back(CONT_PAT | 8'(cp[5:0]));
			end
			default: begin
				str_buf.push_back(LEAD_4B | 8'(cp[20:18]));
				str_buf.push_back(CONT_PAT | 8'(cp[17:12]));
				str_buf.push_back(CONT_PAT | 8'(cp[11:6]));
				str_buf.push_back(CONT_PAT | 8'(cp[5:0]));
			end
		endcase
	endfunction

	// mostly well-formed strings with random content, some noise, some broken
	function automatic void build_random_string();
		int kind;
		int nb;
		logic [CP_W-1:0] cp;
		str_buf.delete();
		kind = $urandom_range(99);
		if (kind < 8) begin
			repeat ($urandom_range(1, 6))
				str_buf.push_back(8'($urandom));
			return;
		end
		repeat ($urandom_range(1, 6)) begin
			nb = $urandom_range(1, 4);
			cp = CP_W'($urandom);
			case (nb)
				1: cp = cp & 21'h00007F;
				2: cp = cp & 21'h0007FF;
				3: cp = cp & 21'h00FFFF;
				default: if ($urandom_range(9) != 0)
					cp = CP_W'($urandom_range(32'h10000, 32'h10FFFF));
			endcase
			push_char(nb, cp);
		end
		if (kind < 22) begin
			case ($urandom_range(2))
				0: str_buf[$urandom_range(str_buf.size() - 1)] = 8'($urandom);
				1: if (str_buf.size() > 1) void'(str_buf.pop_back());
				default: str_buf.insert($urandom_range(str_buf.size() - 1), 8'($urandom));
			endcase
		end
	endfunction

	task automatic run_phase(int tx_pct, int rx_pct, int byte_goal);
		tx_idle_pct = tx_pct;
		rx_idle_pct <= rx_pct;
		while (bytes_sent < byte_goal) begin
			build_random_string();
			send_string();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		text.valid = 1'b0;
		text.data_byte = '0;
		text.last_byte = 1'b0;
		tx_idle_pct = 12;
		rx_idle_pct = 86;
		bytes_sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero byte as a plain character
		str_buf = '{8'h00};
		send_string();
		// top ASCII, then an overlong two-byte zero
		str_buf = '{8'h7F, 8'hC0, 8'h80};
		send_string();
		str_buf = '{8'hE2, 8'h82, 8'hAC};
		send_string();
		// four-byte form takes a surrogate pair
		str_buf = '{8'hF0, 8'h9F, 8'h98, 8'h80};
		send_string();
		// surrogate code point
		str_buf = '{8'hED, 8'hA0, 8'h80};
		send_string();
		// above the Unicode range
		str_buf = '{8'hF4, 8'h90, 8'h80, 8'h80};
		send_string();
		// bad lead, then the rest is skipped
		str_buf = '{8'hFF, 8'h41};
		send_string();
		// missing continuation
		str_buf = '{8'hC3, 8'h41};
		send_string();
		// cut short at the final byte
		str_buf = '{8'hE2, 8'h82};
		send_string();

		run_phase(12, 86, RANDOM_BYTES / 3);
		run_phase(86, 12, 2 * RANDOM_BYTES / 3);
		run_phase(0, 0, RANDOM_BYTES);

		text.valid <= 1'b0;
		@(posedge clk);
		while (results_left != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Checked %0d strings (%0d flagged bad) from %0d bytes,",
			strings_checked, bad_strings, bytes_sent);
		$display("with a slow receiver, then a slow sender, then no stalls.");
		if (fail_count == 0 && results_left == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
